// ----- rtl/tlsrbf_pkg.sv -----
// shared types and constants for the tls record boundary finder
package tlsrbf_pkg;

  localparam int unsigned OffsetWidth = 16;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_FIRST_TYPE = 1'b0,
    CFG_LAST_TYPE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_SEARCH  = 2'd1,
    VERDICT_FLUSH   = 2'd2,
    VERDICT_ABORT   = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] first_type;
    logic [7:0] last_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       segment_end;
  } item_t;

  typedef struct packed {
    logic                   record_done;
    verdict_e               verdict;
    logic [OffsetWidth-1:0] flush_offset;
  } result_t;

endpackage

// ----- rtl/tlsrbf_parser.sv -----
// record header parser, payload counter and segment bookkeeping
module tlsrbf_parser import tlsrbf_pkg::*; #(
  parameter int unsigned SEGMENT_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_VMAJ  = 3'd1,
    PH_VMIN  = 3'd2,
    PH_LEN1  = 3'd3,
    PH_LEN2  = 3'd4,
    PH_DATA  = 3'd5,
    PH_V2L2  = 3'd6,
    PH_V2PAD = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    HALT_NONE  = 2'd0,
    HALT_STOP  = 2'd1,
    HALT_ABORT = 2'd2
  } halt_e;

  localparam logic [SEGMENT_BITS-1:0] PosMax = '1;

  phase_e                  phase_q, phase_d;
  logic                    legacy_q, legacy_d;
  logic [7:0]              len_hi_q, len_hi_d;
  logic [15:0]             left_q, left_d;
  logic [SEGMENT_BITS-1:0] pos_q, pos_d;
  logic [SEGMENT_BITS-1:0] bound_q, bound_d;
  halt_e                   halted_q, halted_d;

  logic [SEGMENT_BITS-1:0] after;
  logic [7:0]              b;
  logic [31:0]             bound_ext;
  logic                    done;
  verdict_e                verdict;

  assign b     = item_i.data_byte;
  assign after = (pos_q != PosMax) ? pos_q + 1'b1 : pos_q;

  always_comb begin
    phase_d   = phase_q;
    legacy_d  = legacy_q;
    len_hi_d  = len_hi_q;
    left_d    = left_q;
    bound_d   = bound_q;
    halted_d  = halted_q;
    done      = 1'b0;
    verdict   = VERDICT_PENDING;
    bound_ext = '0;

    if (halted_q == HALT_NONE) begin
      unique case (phase_q)
        PH_TYPE: begin
          if (b >= cfg_i.first_type && b <= cfg_i.last_type) begin
            legacy_d = 1'b0;
            phase_d  = PH_VMAJ;
          end else if (b[7] || legacy_q) begin
            len_hi_d = b;
            legacy_d = 1'b1;
            phase_d  = PH_V2L2;
          end else begin
            // unknown type: stop if a record already ended, else give up
            halted_d = (bound_q != '0) ? HALT_STOP : HALT_ABORT;
          end
        end
        PH_VMAJ: phase_d = PH_VMIN;
        PH_VMIN: phase_d = PH_LEN1;
        PH_LEN1: begin
          len_hi_d = b;
          phase_d  = PH_LEN2;
        end
        PH_LEN2: begin
          left_d = {len_hi_q, b};
          if ({len_hi_q, b} == 16'd0) begin
            bound_d = after;
            phase_d = PH_TYPE;
            done    = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if (left_q <= 16'd1) begin
            left_d  = '0;
            bound_d = after;
            phase_d = PH_TYPE;
            done    = 1'b1;
          end else begin
            left_d = left_q - 16'd1;
          end
        end
        PH_V2L2: begin
          if (len_hi_q[7]) begin
            // two-byte form, 15-bit length
            left_d = {1'b0, len_hi_q[6:0], b};
            if ({len_hi_q[6:0], b} == 15'd0) begin
              bound_d = after;
              phase_d = PH_TYPE;
              done    = 1'b1;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            // three-byte form, 14-bit length then pad
            left_d  = {2'b00, len_hi_q[5:0], b};
            phase_d = PH_V2PAD;
          end
        end
        PH_V2PAD: begin
          if (left_q == 16'd0) begin
            bound_d = after;
            phase_d = PH_TYPE;
            done    = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
      endcase
    end

    pos_d = after;

    if (item_i.segment_end) begin
      if (halted_d == HALT_ABORT) begin
        verdict = VERDICT_ABORT;
      end else if (bound_d != '0) begin
        verdict   = VERDICT_FLUSH;
        bound_ext = 32'(bound_d);
        left_d    = '0;
        phase_d   = PH_TYPE;
      end else begin
        verdict = VERDICT_SEARCH;
      end
      pos_d    = '0;
      bound_d  = '0;
      halted_d = HALT_NONE;
    end
  end

  assign result_o.record_done  = done;
  assign result_o.verdict      = verdict;
  assign result_o.flush_offset = bound_ext[OffsetWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TYPE;
      legacy_q <= 1'b0;
      len_hi_q <= '0;
      left_q   <= '0;
      pos_q    <= '0;
      bound_q  <= '0;
      halted_q <= HALT_NONE;
    end else if (step_i) begin
      phase_q  <= phase_d;
      legacy_q <= legacy_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      bound_q  <= bound_d;
      halted_q <= halted_d;
    end
  end

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.segment_end |=> pos_q == '0 && bound_q == '0)
    else $error("segment counters not cleared at segment end");

  a_abort_no_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q == HALT_ABORT |-> bound_q == '0)
    else $error("aborted segment holds a record boundary");

  a_stop_has_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q == HALT_STOP |-> bound_q != '0)
    else $error("stopped segment without a record boundary");

  a_done_to_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> phase_q == PH_TYPE)
    else $error("parser not back at record type after a record end");

endmodule

// ----- rtl/tls_record_boundary_finder_core.sv -----
// path: a byte goes from the input register through the parser step into the result register
// throughput: one byte per cycle unless out_stall_i holds the result register
// the result register frees the input side while an earlier result waits for transfer
// reset: asynchronous, active low; parser idle expecting a record type, counters zero
// configuration resets to type range 20..24
module tls_record_boundary_finder_core import tlsrbf_pkg::*; #(
  parameter int unsigned SEGMENT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        segment_end_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_done_o,
  output logic [1:0]  verdict_o,
  output logic [15:0] flush_offset_o
);

  cfg_t    cfg_q;
  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t step_res;
  logic    s1_advance;
  logic    in_xfer;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_type <= 8'd20;
      cfg_q.last_type  <= 8'd24;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_FIRST_TYPE: cfg_q.first_type <= cfg_data_i;
        CFG_LAST_TYPE:  cfg_q.last_type  <= cfg_data_i;
      endcase
    end
  end

  // the held byte moves on when the result register is empty or being drained
  assign s1_advance = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.data_byte   <= data_byte_i;
      s1_item_q.segment_end <= segment_end_i;
    end
  end

  // parser state steps exactly once per byte, as it enters the result register
  tlsrbf_parser #(
    .SEGMENT_BITS(SEGMENT_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_advance),
    .item_i  (s1_item_q),
    .cfg_i   (cfg_q),
    .result_o(step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_done_o  = out_res_q.record_done;
  assign verdict_o      = out_res_q.verdict;
  assign flush_offset_o = out_res_q.flush_offset;

endmodule
